// ===== design/fts_pkg.sv =====
// Package for the FAT timestamp block: field widths, reciprocal constants,
// register codes, the pipeline's carried item type and the month-length table.
// No dependencies.
`default_nettype none

package fts_pkg;

  // Widths of the intermediate counts. The widest uptime gives at most
  // 4 294 967 s, which fits 23 bits, and a day count before the month walk
  // below 90.
  localparam int unsigned SEC_W = 23;
  localparam int unsigned MIN_W = 17;
  localparam int unsigned HR_W  = 11;
  localparam int unsigned DAY_W = 7;
  localparam int unsigned YR_W  = 13;

  // Reciprocals for exact division by a constant: q = (x * MUL) >> SH.
  localparam logic [28:0] DIV1000_MUL = 29'd274877907;
  localparam int unsigned DIV1000_SH  = 38;
  localparam logic [23:0] DIV60S_MUL  = 24'd8947849;
  localparam int unsigned DIV60S_SH   = 29;
  localparam logic [17:0] DIV60M_MUL  = 18'd139811;
  localparam int unsigned DIV60M_SH   = 23;
  localparam logic [11:0] DIV24_MUL   = 12'd2731;
  localparam int unsigned DIV24_SH    = 16;
  localparam logic [13:0] DIV25_MUL   = 14'd10486;
  localparam int unsigned DIV25_SH    = 18;

  // Number of month steps in the walk; two always suffice, one spare.
  localparam int unsigned WALK_STEPS = 3;

  localparam logic [11:0] YEAR_MIN = 12'd1980;
  localparam logic [11:0] YEAR_MAX = 12'd2107;

  // Configuration register reset values.
  localparam logic [11:0] RST_YEAR   = 12'd1980;
  localparam logic [3:0]  RST_MONTH  = 4'd1;
  localparam logic [4:0]  RST_DAY    = 5'd1;
  localparam logic [4:0]  RST_HOUR   = 5'd0;
  localparam logic [5:0]  RST_MINUTE = 6'd0;
  localparam logic [5:0]  RST_SECOND = 6'd0;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    REG_BASE_YEAR   = 3'd0,
    REG_BASE_MONTH  = 3'd1,
    REG_BASE_DAY    = 3'd2,
    REG_BASE_HOUR   = 3'd3,
    REG_BASE_MINUTE = 3'd4,
    REG_BASE_SECOND = 3'd5
  } cfg_reg_e;

  // Item as it travels through the month walk.
  typedef struct packed {
    logic             valid;
    logic             yinc;
    logic [3:0]       month;
    logic [DAY_W-1:0] day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } walk_t;

  // Length of a month; month is already in 1..12.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      unique case (month)
        MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/fts_clock_pipe.sv =====
// Time-of-day part of the FAT timestamp pipeline: eight register stages that
// split the uptime into seconds, minutes, hours and a day count.
// Depends on fts_pkg.
`default_nettype none

module fts_clock_pipe (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [31:0]           uptime_ms_i,
  input  wire logic [3:0]            base_month_i,
  input  wire logic [4:0]            base_day_i,
  input  wire logic [4:0]            base_hour_i,
  input  wire logic [5:0]            base_minute_i,
  input  wire logic [5:0]            base_second_i,
  output fts_pkg::walk_t             item_o
);

  localparam int unsigned SW = fts_pkg::SEC_W;
  localparam int unsigned MW = fts_pkg::MIN_W;
  localparam int unsigned HW = fts_pkg::HR_W;
  localparam int unsigned DW = fts_pkg::DAY_W;

  logic [7:0] valid_q;

  // Stage payload registers.
  logic [SW-1:0] q1_q;
  logic [SW-1:0] sec2_q;
  logic [SW-1:0] sec3_q;
  logic [MW-1:0] sq3_q;
  logic [5:0]    sec4_q, sec5_q, sec6_q, sec7_q, sec8_q;
  logic [MW-1:0] min4_q, min5_q;
  logic [HW-1:0] mq5_q;
  logic [5:0]    min6_q, min7_q, min8_q;
  logic [HW-1:0] hr6_q, hr7_q;
  logic [5:0]    hq7_q;
  logic [4:0]    hr8_q;
  logic [DW-1:0] day8_q;
  logic [3:0]    mon8_q;

  logic [60:0]   p1;
  logic [46:0]   p3;
  logic [34:0]   p5;
  logic [22:0]   p7;
  logic [SW-1:0] sq60;
  logic [MW-1:0] mq60;
  logic [9:0]    hq24;
  logic [SW-1:0] sec_rem;
  logic [MW-1:0] min_rem;
  logic [HW-1:0] hr_rem;
  logic [4:0]    day_norm;
  logic [3:0]    mon_norm;

  assign p1 = 61'(uptime_ms_i) * 61'(fts_pkg::DIV1000_MUL);
  assign p3 = 47'(sec2_q) * 47'(fts_pkg::DIV60S_MUL);
  assign p5 = 35'(min4_q) * 35'(fts_pkg::DIV60M_MUL);
  assign p7 = 23'(hr6_q) * 23'(fts_pkg::DIV24_MUL);

  // Quotient times 60 as 64q - 4q, times 24 as 16q + 8q.
  assign sq60    = {sq3_q, 6'b0} - {4'b0, sq3_q, 2'b0};
  assign mq60    = {mq5_q, 6'b0} - {4'b0, mq5_q, 2'b0};
  assign hq24    = {hq7_q, 4'b0} + {1'b0, hq7_q, 3'b0};
  assign sec_rem = sec3_q - sq60;
  assign min_rem = min5_q - mq60;
  assign hr_rem  = hr7_q - HW'(hq24);

  // A zero day counts as the first; months outside 1..12 are pulled in.
  assign day_norm = (base_day_i == 5'd0) ? 5'd1 : base_day_i;
  always_comb begin
    if (base_month_i == 4'd0) begin
      mon_norm = fts_pkg::MONTH_JAN;
    end else if (base_month_i > fts_pkg::MONTH_DEC) begin
      mon_norm = fts_pkg::MONTH_DEC;
    end else begin
      mon_norm = base_month_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q   <= p1[fts_pkg::DIV1000_SH +: SW];
    sec2_q <= q1_q + SW'(base_second_i);
    sec3_q <= sec2_q;
    sq3_q  <= p3[fts_pkg::DIV60S_SH +: MW];
    sec4_q <= sec_rem[5:0];
    min4_q <= sq3_q + MW'(base_minute_i);
    sec5_q <= sec4_q;
    min5_q <= min4_q;
    mq5_q  <= p5[fts_pkg::DIV60M_SH +: HW];
    sec6_q <= sec5_q;
    min6_q <= min_rem[5:0];
    hr6_q  <= mq5_q + HW'(base_hour_i);
    sec7_q <= sec6_q;
    min7_q <= min6_q;
    hr7_q  <= hr6_q;
    hq7_q  <= p7[fts_pkg::DIV24_SH +: 6];
    sec8_q <= sec7_q;
    min8_q <= min7_q;
    hr8_q  <= hr_rem[4:0];
    day8_q <= DW'(day_norm) + DW'(hq7_q);
    mon8_q <= mon_norm;
  end

  assign item_o = '{valid:  valid_q[7],
                    yinc:   1'b0,
                    month:  mon8_q,
                    day:    day8_q,
                    hour:   hr8_q,
                    minute: min8_q,
                    second: sec8_q};

endmodule

`default_nettype wire

// ===== design/fts_walk_step.sv =====
// One registered step of the month walk: moves surplus days into the next
// month, wrapping December into January of the following year.
// Depends on fts_pkg.
`default_nettype none

module fts_walk_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           leap0_i,
  input  wire logic           leap1_i,
  input  wire fts_pkg::walk_t item_i,
  output fts_pkg::walk_t      item_o
);

  fts_pkg::walk_t item_d, item_q;
  logic [4:0]     len;
  logic           valid_q;

  assign len = fts_pkg::days_in(item_i.month, item_i.yinc ? leap1_i : leap0_i);

  always_comb begin
    item_d = item_i;
    if (item_i.day > fts_pkg::DAY_W'(len)) begin
      item_d.day = item_i.day - fts_pkg::DAY_W'(len);
      if (item_i.month == fts_pkg::MONTH_DEC) begin
        item_d.month = fts_pkg::MONTH_JAN;
        item_d.yinc  = 1'b1;
      end else begin
        item_d.month = item_i.month + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== design/fat_timestamp_from_uptime.sv =====
// Top level of the FAT timestamp block: configuration registers, leap-year
// flags, the time-of-day pipeline, the month walk and the output packer.
// Depends on fts_pkg, fts_clock_pipe and fts_walk_step.
`default_nettype none

// Pipeline: a taken start transaction passes eight stages of time-of-day
//   arithmetic, three month-walk steps and the output register before its
//   result appears. The pipeline is fully unrolled, so one transaction is
//   accepted every cycle while busy_o is low; done_o pulses once per transaction.
// Reset: asynchronous, active low. All valid bits clear, the reference date
//   returns to 1 January 1980 00:00:00 and busy_o is high for one cycle after.
module fat_timestamp_from_uptime (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Command channel.
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] uptime_ms_i,
  // Result strobe and payload.
  output logic             done_o,
  output logic [31:0]      fat_stamp_o,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  localparam int unsigned YW = fts_pkg::YR_W;
  localparam int unsigned NS = fts_pkg::WALK_STEPS;

  // Reference date and time registers.
  logic [11:0] base_year_q;
  logic [3:0]  base_month_q;
  logic [4:0]  base_day_q;
  logic [4:0]  base_hour_q;
  logic [5:0]  base_minute_q;
  logic [5:0]  base_second_q;

  logic        busy_q;
  logic        cfg_write;

  // The user must change registers only between transactions; the block does
  // not enforce it. The leap flags for the reference year and the year after
  // it are kept in a small two-stage pipe of their own that follows base_year_q.
  logic [YW-1:0] year0, year1;
  logic [26:0]   yp0, yp1;
  logic [8:0]    yq0_q, yq1_q;
  logic [YW-1:0] y25_0, y25_1;
  logic [YW-1:0] r0, r1;
  logic          leap0_q, leap1_q;

  fts_pkg::walk_t walk [NS+1];

  logic [YW-1:0] year_out;
  logic [6:0]    year_field;
  logic [31:0]   stamp_d, stamp_q;
  logic          done_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign busy_o      = busy_q;

  // The block keeps no state between transactions; busy only covers the
  // first cycle out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q   <= fts_pkg::RST_YEAR;
      base_month_q  <= fts_pkg::RST_MONTH;
      base_day_q    <= fts_pkg::RST_DAY;
      base_hour_q   <= fts_pkg::RST_HOUR;
      base_minute_q <= fts_pkg::RST_MINUTE;
      base_second_q <= fts_pkg::RST_SECOND;
    end else if (cfg_write) begin
      unique case (fts_pkg::cfg_reg_e'(cfg_index_i))
        fts_pkg::REG_BASE_YEAR:   base_year_q   <= cfg_data_i;
        fts_pkg::REG_BASE_MONTH:  base_month_q  <= cfg_data_i[3:0];
        fts_pkg::REG_BASE_DAY:    base_day_q    <= cfg_data_i[4:0];
        fts_pkg::REG_BASE_HOUR:   base_hour_q   <= cfg_data_i[4:0];
        fts_pkg::REG_BASE_MINUTE: base_minute_q <= cfg_data_i[5:0];
        fts_pkg::REG_BASE_SECOND: base_second_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Leap rule: divisible by 4, and either not by 100 or by 400. For a
  // multiple of 4 that is: not a multiple of 25, or a multiple of 16.
  assign year0 = YW'(base_year_q);
  assign year1 = year0 + YW'(1);
  assign yp0   = 27'(year0) * 27'(fts_pkg::DIV25_MUL);
  assign yp1   = 27'(year1) * 27'(fts_pkg::DIV25_MUL);
  assign y25_0 = {yq0_q, 4'b0} + {1'b0, yq0_q, 3'b0} + {4'b0, yq0_q};
  assign y25_1 = {yq1_q, 4'b0} + {1'b0, yq1_q, 3'b0} + {4'b0, yq1_q};
  assign r0    = year0 - y25_0;
  assign r1    = year1 - y25_1;

  always_ff @(posedge clk_i) begin
    yq0_q   <= yp0[fts_pkg::DIV25_SH +: 9];
    yq1_q   <= yp1[fts_pkg::DIV25_SH +: 9];
    leap0_q <= (year0[1:0] == 2'b00) && ((r0 != '0) || (year0[3:0] == 4'b0000));
    leap1_q <= (year1[1:0] == 2'b00) && ((r1 != '0) || (year1[3:0] == 4'b0000));
  end

  fts_clock_pipe u_clock (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (start_i & ~busy_q),
    .uptime_ms_i   (uptime_ms_i),
    .base_month_i  (base_month_q),
    .base_day_i    (base_day_q),
    .base_hour_i   (base_hour_q),
    .base_minute_i (base_minute_q),
    .base_second_i (base_second_q),
    .item_o        (walk[0])
  );

  // The day count stays below 90, so two month steps always finish the walk;
  // the third step passes its item through unchanged.
  for (genvar g = 0; g < NS; g++) begin : g_walk
    fts_walk_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .leap0_i (leap0_q),
      .leap1_i (leap1_q),
      .item_i  (walk[g]),
      .item_o  (walk[g+1])
    );
  end

  // The walk advances the year by at most one; clamp to the FAT range.
  assign year_out = year0 + YW'(walk[NS].yinc);
  always_comb begin
    if (year_out < YW'(fts_pkg::YEAR_MIN)) begin
      year_field = 7'd0;
    end else if (year_out > YW'(fts_pkg::YEAR_MAX)) begin
      year_field = 7'(fts_pkg::YEAR_MAX - fts_pkg::YEAR_MIN);
    end else begin
      year_field = 7'(year_out - YW'(fts_pkg::YEAR_MIN));
    end
  end

  assign stamp_d = {year_field, walk[NS].month, walk[NS].day[4:0], walk[NS].hour,
                    walk[NS].minute, walk[NS].second[5:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= walk[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
  end

  assign done_o      = done_q;
  assign fat_stamp_o = stamp_q;

  // Every accepted transaction yields its result once it has passed the pipeline.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##12 done_o)
    else $error("accepted transaction gave no result after 12 cycles");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 12))
    else $error("result without a matching transaction");

  // The walk leaves a valid month and a non-zero day no longer than February allows.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fat_stamp_o[24:21] != 4'd0) && (fat_stamp_o[24:21] <= 4'd12) &&
               (fat_stamp_o[20:16] != 5'd0) &&
               ((fat_stamp_o[24:21] != 4'd2) || (fat_stamp_o[20:16] <= 5'd29)))
    else $error("month or day out of range after the walk");

  // The carries leave hours, minutes and halved seconds within their ranges.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fat_stamp_o[15:11] < 5'd24) && (fat_stamp_o[10:5] < 6'd60) &&
               (fat_stamp_o[4:0] < 5'd30))
    else $error("time of day out of range");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for fat_timestamp_from_uptime: directed and random uptimes
// under many reference dates, each result compared with an in-bench calendar predictor.
// Depends on fts_pkg and the fat_timestamp_from_uptime RTL.
`timescale 1ns / 100ps

module tb_top;

  // Clock, reset and every input of the block start at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic [31:0] uptime_ms_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i  = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] fat_stamp_o;
  logic        cfg_ready_o;

  fat_timestamp_from_uptime uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .uptime_ms_i (uptime_ms_i),
    .done_o      (done_o),
    .fat_stamp_o (fat_stamp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Each accepted uptime leaves one expected stamp here, oldest first.
  typedef struct {
    logic [31:0] uptime;
    logic [31:0] stamp;
  } stamp_due_t;

  stamp_due_t  stamps_due[$];
  stamp_due_t  oldest_due;
  int unsigned err_count = 0;
  int unsigned shown     = 0;
  bit          idle_en   = 1'b1;

  // Bench copy of the reference date, held at the register widths so that
  // writes with stray upper bits are truncated exactly as the block does.
  logic [11:0] ref_year   = fts_pkg::RST_YEAR;
  logic [3:0]  ref_month  = fts_pkg::RST_MONTH;
  logic [4:0]  ref_day    = fts_pkg::RST_DAY;
  logic [4:0]  ref_hour   = fts_pkg::RST_HOUR;
  logic [5:0]  ref_minute = fts_pkg::RST_MINUTE;
  logic [5:0]  ref_second = fts_pkg::RST_SECOND;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a correct run needs only a small fraction of this.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian rule on the unclamped year, so years outside 1980..2107 still
  // get the right February while the walk runs.
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    case (mon)
      2:         return leap_year(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:   return 31;
    endcase
  endfunction

  // Stamp that the block should give for one uptime under the current date.
  function automatic logic [31:0] fat_stamp_of(input logic [31:0] ms);
    int unsigned secs;
    int unsigned mins;
    int unsigned hrs;
    int unsigned day;
    int unsigned mon;
    int unsigned yr;
    secs = 32'(ref_second) + ms / 32'd1000;
    mins = 32'(ref_minute) + secs / 60;
    hrs  = 32'(ref_hour) + mins / 60;
    day  = (ref_day == 0) ? 1 : 32'(ref_day);
    mon  = 32'(ref_month);
    yr   = 32'(ref_year);
    // A zero month counts as January and anything past twelve as December.
    if (mon == 0) mon = 1;
    if (mon > 12) mon = 12;
    day  = day + hrs / 24;
    secs = secs % 60;
    mins = mins % 60;
    hrs  = hrs % 24;
    // Surplus days walk forward month by month, wrapping into the next year.
    while (day > month_length(mon, yr)) begin
      day = day - month_length(mon, yr);
      mon++;
      if (mon > 12) begin
        mon = 1;
        yr++;
      end
    end
    // The year field only spans 1980..2107, so the walked year is clamped.
    if (yr < 1980) yr = 1980;
    if (yr > 2107) yr = 2107;
    return {7'(yr - 1980), 4'(mon), 5'(day), 5'(hrs), 6'(mins), 5'(secs / 2)};
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks. Every task is entered just after a rising edge and
  // returns just after one, so each signal sees at most one update per step.
  // ---------------------------------------------------------------------------

  // Offers one uptime and waits for its start transaction to be taken. A
  // random idle burst may come first; start stays high between back-to-back
  // transactions.
  task automatic send_uptime(input logic [31:0] ms);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    uptime_ms_i <= ms;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    stamps_due.push_back('{uptime: ms, stamp: fat_stamp_of(ms)});
  endtask

  // Lowers start and waits until every expected stamp has arrived, then lets
  // the pipeline's latency pass. The wait is bounded; stamps still missing are
  // reported at the end.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    while (stamps_due.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
  endtask

  // One configuration transaction. Valid is left high; set_base lowers it
  // once the whole batch is written.
  task automatic write_reg(input fts_pkg::cfg_reg_e idx, input logic [11:0] data);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      fts_pkg::REG_BASE_YEAR:   ref_year   = data;
      fts_pkg::REG_BASE_MONTH:  ref_month  = data[3:0];
      fts_pkg::REG_BASE_DAY:    ref_day    = data[4:0];
      fts_pkg::REG_BASE_HOUR:   ref_hour   = data[4:0];
      fts_pkg::REG_BASE_MINUTE: ref_minute = data[5:0];
      fts_pkg::REG_BASE_SECOND: ref_second = data[5:0];
      default: ;
    endcase
  endtask

  // Loads a whole reference date, only once the block has gone quiet.
  task automatic set_base(input logic [11:0] yr, input logic [11:0] mon,
                          input logic [11:0] day, input logic [11:0] hr,
                          input logic [11:0] mn, input logic [11:0] sc);
    wait_idle();
    write_reg(fts_pkg::REG_BASE_YEAR, yr);
    write_reg(fts_pkg::REG_BASE_MONTH, mon);
    write_reg(fts_pkg::REG_BASE_DAY, day);
    write_reg(fts_pkg::REG_BASE_HOUR, hr);
    write_reg(fts_pkg::REG_BASE_MINUTE, mn);
    write_reg(fts_pkg::REG_BASE_SECOND, sc);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: the receiver cannot stall, so every strobe is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (stamps_due.size() == 0) begin
        err_count++;
        if (shown < 10) begin
          shown++;
          $display("%0t: stamp %h arrived with none expected", $realtime, fat_stamp_o);
        end
      end else begin
        oldest_due = stamps_due.pop_front();
        if (fat_stamp_o !== oldest_due.stamp) begin
          err_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t: uptime %0d ms: expected stamp %h, got %h", $realtime,
                     oldest_due.uptime, oldest_due.stamp, fat_stamp_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset date of 1 January 1980: each unit boundary of the carry chain, the
  // month rollover at 31 days and the widest uptime.
  task automatic test_time_carries();
    send_uptime(32'd0);
    send_uptime(32'd999);
    send_uptime(32'd1000);
    send_uptime(32'd59_999);
    send_uptime(32'd60_000);
    send_uptime(32'd3_599_999);
    send_uptime(32'd86_399_999);
    send_uptime(32'd86_400_000);
    send_uptime(32'd2_678_400_000);
    send_uptime(32'hFFFF_FFFF);
  endtask

  // Register extremes and the odd reference dates the block must tolerate.
  task automatic test_register_extremes();
    // Last second of the top year: one more second pushes the year past the
    // field and it must clamp.
    set_base(12'd2107, 12'd12, 12'd31, 12'd23, 12'd59, 12'd59);
    send_uptime(32'd0);
    send_uptime(32'd1000);
    // Every field at its register maximum: zero-free overflow of the time
    // fields, a month past December and a year far above the range.
    set_base(12'hFFF, 12'h00F, 12'h01F, 12'h01F, 12'h03F, 12'h03F);
    send_uptime(32'd0);
    send_uptime(32'hFFFF_FFFF);
    // Zero month and zero day, with a year below the range.
    set_base(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_uptime(32'd0);
    send_uptime(32'd2_678_399_999);
    // The 31st of February in a leap century and in a plain century, and the
    // 29th of February in a plain century that is clamped upwards afterwards.
    set_base(12'd2000, 12'd2, 12'd31, 12'd0, 12'd0, 12'd0);
    send_uptime(32'd0);
    set_base(12'd2100, 12'd2, 12'd31, 12'd12, 12'd0, 12'd0);
    send_uptime(32'd0);
    set_base(12'd1900, 12'd2, 12'd29, 12'd0, 12'd0, 12'd0);
    send_uptime(32'd0);
    // One second before midnight on 28 February, leap and common year.
    set_base(12'd2024, 12'd2, 12'd28, 12'd23, 12'd59, 12'd59);
    send_uptime(32'd1000);
    set_base(12'd2023, 12'd2, 12'd28, 12'd23, 12'd59, 12'd59);
    send_uptime(32'd1000);
  endtask

  // Uptimes spread over the whole range, with weight on the unit boundaries
  // and on short spans that keep the walk within a month or two.
  function automatic logic [31:0] random_uptime();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 120_000);
      1:       return $urandom_range(0, 5) * 32'd1000 + $urandom_range(0, 1) * 32'd999;
      2:       return $urandom_range(0, 3 * 86_400) * 32'd1000 + $urandom_range(0, 999);
      3:       return $urandom_range(1, 40) * 32'd86_400_000 - $urandom_range(0, 1000);
      4:       return 32'hFFFF_FFFF - $urandom_range(0, 100_000);
      default: return $urandom();
    endcase
  endfunction

  // Reference date mostly in range, sometimes anything the register holds;
  // every field but the year also gets random bits above its register width.
  task automatic pick_random_base();
    logic [11:0] yr, mon, day, hr, mn, sc;
    yr  = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(1980, 2107));
    mon = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 15)) : 12'($urandom_range(1, 12));
    day = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(26, 31)) : 12'($urandom_range(0, 31));
    hr  = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 31)) : 12'($urandom_range(0, 23));
    mn  = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 63)) : 12'($urandom_range(0, 59));
    sc  = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 63)) : 12'($urandom_range(0, 59));
    mon[11:4] = 8'($urandom());
    day[11:5] = 7'($urandom());
    hr[11:5]  = 7'($urandom());
    mn[11:6]  = 6'($urandom());
    sc[11:6]  = 6'($urandom());
    set_base(yr, mon, day, hr, mn, sc);
  endtask

  // Several random reference dates, each followed by a run of random uptimes
  // with idle bursts on both channels.
  task automatic test_random_dates();
    repeat (7) begin
      pick_random_base();
      repeat (200) send_uptime(random_uptime());
    end
  endtask

  // Final stretch without idle bursts: one transaction per cycle while busy_o is low, back to back.
  task automatic test_full_rate();
    idle_en = 1'b0;
    pick_random_base();
    repeat (200) send_uptime(random_uptime());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_time_carries();
    test_register_extremes();
    test_random_dates();
    test_full_rate();
    wait_idle();
    if (stamps_due.size() != 0) begin
      err_count += stamps_due.size();
      $display("%0d expected stamps never arrived", stamps_due.size());
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
